// File: src/cbf_pkg.sv
// ============================================================================
// cbf_pkg
// Shared types and constants of the counting Bloom filter: opcodes, the
// classified item that travels from the front end to the update engine,
// register addresses and store geometry.
// ============================================================================
package cbf_pkg;

    // Store geometry and key layout.
    localparam int INDEX_BITS  = 16;
    localparam int MAX_HASHES  = 5;
    localparam int STORE_DEPTH = 1 << INDEX_BITS;
    localparam int CTR_W       = 4;
    localparam int HASH_W      = 3;
    localparam int IDXW_W      = 5;
    localparam int STEP_W      = $clog2(MAX_HASHES + 1);

    // Counter limits.
    localparam logic [CTR_W-1:0] CTR_MAX  = 4'hF;
    localparam logic [CTR_W-1:0] CTR_ZERO = 4'h0;

    // Reset values of the configuration registers.
    localparam logic [HASH_W-1:0] HASHES_RESET  = 3'd5;
    localparam logic [IDXW_W-1:0] IDX_W_RESET   = 5'd16;
    localparam logic [HASH_W-1:0] HASHES_LIMIT  = HASH_W'(MAX_HASHES);

    // Configuration port geometry: register index sits in paddr[2].
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_HASHES = 1'b0;
    localparam logic REG_IDX_W  = 1'b1;

    // Depth of the queue between front end and update engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation codes.
    typedef enum logic [1:0] {
        OP_TEST = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // Update engine states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } bstate_t;

    // One classified item: opcode, number of counters and their indices.
    typedef struct packed {
        op_t                                  op;
        logic [HASH_W-1:0]                    hashes;
        logic [MAX_HASHES-1:0][INDEX_BITS-1:0] idx;
    } item_t;

    // Queue status seen by the front end and the engine.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Completion reported by the engine.
    typedef struct packed {
        logic done;
        logic member;
    } result_t;

endpackage

// File: src/cbf_front.sv
// ============================================================================
// cbf_front
// Front end: accepts a command, masks the key words to the configured index
// width, clamps the hash count and pushes the classified item into the queue.
// ============================================================================
module cbf_front (
    input  logic                                start,
    input  logic [1:0]                          opcode,
    input  logic [31:0]                         key_word0,
    input  logic [31:0]                         key_word1,
    input  logic [31:0]                         key_word2,
    input  logic [31:0]                         key_word3,
    input  logic [31:0]                         key_word4,
    input  logic [cbf_pkg::HASH_W-1:0]          hashes_per_key,
    input  logic [cbf_pkg::IDXW_W-1:0]          index_width,
    input  logic                                clearing,
    input  cbf_pkg::q_status_t                  q_status,
    output logic                                busy,
    output logic                                push,
    output cbf_pkg::item_t                      item
);

    logic [cbf_pkg::INDEX_BITS-1:0]                          mask;
    logic [cbf_pkg::MAX_HASHES-1:0][31:0]                    words;

    // Busy while the store is being cleared or the queue has no room.
    assign busy = clearing || q_status.full;
    assign push = start && !busy;

    assign words[0] = key_word0;
    assign words[1] = key_word1;
    assign words[2] = key_word2;
    assign words[3] = key_word3;
    assign words[4] = key_word4;

    // Index mask: bit j is kept when j lies below the configured width.
    always_comb
    begin
        for (int j = 0; j < cbf_pkg::INDEX_BITS; j++)
        begin
            mask[j] = (index_width > cbf_pkg::IDXW_W'(j));
        end
    end

    // Classified item.
    always_comb
    begin
        item.op     = cbf_pkg::op_t'(opcode);
        item.hashes = (hashes_per_key > cbf_pkg::HASHES_LIMIT) ?
                      cbf_pkg::HASHES_LIMIT : hashes_per_key;
        for (int i = 0; i < cbf_pkg::MAX_HASHES; i++)
        begin
            item.idx[i] = words[i][cbf_pkg::INDEX_BITS-1:0] & mask;
        end
    end

endmodule

// File: src/cbf_queue.sv
// ============================================================================
// cbf_queue
// Short queue of classified items between the front end and the update
// engine, so that each side can stall on its own.
// ============================================================================
module cbf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbf_pkg::item_t      push_item,
    input  logic                pop,
    output cbf_pkg::item_t      pop_item,
    output cbf_pkg::q_status_t  status
);

    cbf_pkg::item_t                   slot_reg [cbf_pkg::Q_DEPTH];
    logic [cbf_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cbf_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cbf_pkg::Q_CNT_W-1:0]      count_reg, count_next;

    assign status.full  = (count_reg == cbf_pkg::Q_CNT_W'(cbf_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == cbf_pkg::Q_PTR_W'(cbf_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cbf_pkg::Q_PTR_W'(cbf_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue push while full");

    // The engine never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");

    // The fill count never exceeds the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cbf_pkg::Q_CNT_W'(cbf_pkg::Q_DEPTH))
        else $error("queue count out of range");

endmodule

// File: src/cbf_back.sv
// ============================================================================
// cbf_back
// Update engine: clears the counter store after reset, then takes items from
// the queue and runs one counter read-modify-write per cycle on the store,
// forwarding the last written value when an index repeats back to back.
// ============================================================================
module cbf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cbf_pkg::item_t      q_item,
    input  cbf_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                clearing,
    output cbf_pkg::result_t    result
);

    // Counter store.
    logic [cbf_pkg::CTR_W-1:0]        mem [cbf_pkg::STORE_DEPTH];

    cbf_pkg::bstate_t                 state_reg, state_next;
    logic [cbf_pkg::INDEX_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    cbf_pkg::item_t                   item_reg, item_next;
    logic [cbf_pkg::STEP_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                             pend_reg, pend_next;
    logic [cbf_pkg::INDEX_BITS-1:0]   pend_idx_reg, pend_idx_next;
    logic                             fwd_reg, fwd_next;
    logic [cbf_pkg::CTR_W-1:0]        last_wdata_reg, last_wdata_next;
    logic                             all_set_reg, all_set_next;
    logic [cbf_pkg::CTR_W-1:0]        rdata_reg;

    logic                             issue;
    logic [cbf_pkg::INDEX_BITS-1:0]   raddr;
    logic [cbf_pkg::CTR_W-1:0]        cur;
    logic [cbf_pkg::CTR_W-1:0]        upd;
    logic                             we;
    logic [cbf_pkg::INDEX_BITS-1:0]   waddr;
    logic [cbf_pkg::CTR_W-1:0]        wdata;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbf_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == cbf_pkg::INDEX_BITS'(cbf_pkg::STORE_DEPTH - 1))
                begin
                    state_next = cbf_pkg::ST_IDLE;
                end
            end
            cbf_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = cbf_pkg::ST_RUN;
                end
            end
            cbf_pkg::ST_RUN:
            begin
                if (rd_cnt_reg == item_reg.hashes)
                begin
                    state_next = cbf_pkg::ST_DONE;
                end
            end
            cbf_pkg::ST_DONE:
            begin
                state_next = q_status.empty ? cbf_pkg::ST_IDLE : cbf_pkg::ST_RUN;
            end
            default:
            begin
                state_next = cbf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        clearing = 1'b0;
        pop      = 1'b0;
        issue    = 1'b0;
        result   = '0;
        case (state_reg)
            cbf_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            cbf_pkg::ST_IDLE:
            begin
                pop = !q_status.empty;
            end
            cbf_pkg::ST_RUN:
            begin
                issue = (rd_cnt_reg < item_reg.hashes);
            end
            cbf_pkg::ST_DONE:
            begin
                pop           = !q_status.empty;
                result.done   = 1'b1;
                result.member = (item_reg.op == cbf_pkg::OP_TEST) && all_set_reg;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Counter value for the step in flight, and its updated value.
    assign cur = fwd_reg ? last_wdata_reg : rdata_reg;

    always_comb
    begin
        upd = cur;
        case (item_reg.op)
            cbf_pkg::OP_ADD:
            begin
                if (cur != cbf_pkg::CTR_MAX)
                begin
                    upd = cur + 1'b1;
                end
            end
            cbf_pkg::OP_DEL:
            begin
                if (cur != cbf_pkg::CTR_ZERO && cur != cbf_pkg::CTR_MAX)
                begin
                    upd = cur - 1'b1;
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    // Store port selection: clearing pass or write-back of the step in flight.
    assign raddr = issue ? item_reg.idx[rd_cnt_reg] : '0;

    always_comb
    begin
        if (clearing)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = cbf_pkg::CTR_ZERO;
        end
        else
        begin
            we    = pend_reg && (item_reg.op == cbf_pkg::OP_ADD ||
                                 item_reg.op == cbf_pkg::OP_DEL);
            waddr = pend_idx_reg;
            wdata = upd;
        end
    end

    // Sequencing of item load, read issue and step completion.
    always_comb
    begin
        clr_cnt_next    = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        item_next       = item_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = issue;
        pend_idx_next   = issue ? raddr : pend_idx_reg;
        fwd_next        = issue && pend_reg && (raddr == pend_idx_reg);
        last_wdata_next = pend_reg ? upd : last_wdata_reg;
        all_set_next    = all_set_reg;
        if (pop)
        begin
            item_next    = q_item;
            rd_cnt_next  = '0;
            all_set_next = 1'b1;
        end
        else
        begin
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            if (pend_reg && cur == cbf_pkg::CTR_ZERO)
            begin
                all_set_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cbf_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            fwd_reg     <= 1'b0;
            all_set_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            pend_reg    <= pend_next;
            fwd_reg     <= fwd_next;
            all_set_reg <= all_set_next;
        end
    end

    // Payload registers of the item in flight.
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pend_idx_reg   <= pend_idx_next;
        last_wdata_reg <= last_wdata_next;
    end

    // Counter store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // No counter read is issued during the clearing pass.
    a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !issue && !pend_reg)
        else $error("counter access during clearing pass");

    // Forwarding only follows a step that was in flight the cycle before.
    a_fwd_after_pend: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> pend_reg && $past(pend_reg))
        else $error("forwarding without a preceding write-back");

    // A result is reported only after the last write-back is done.
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> !pend_reg && !issue)
        else $error("result reported with a step still in flight");

    // The read step count never passes the item's hash count.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbf_pkg::ST_RUN) |-> rd_cnt_reg <= item_reg.hashes)
        else $error("read step beyond hash count");

endmodule

// File: src/counting_bloom_filter.sv
// ============================================================================
// counting_bloom_filter
// Counting Bloom filter over 65536 four-bit saturating counters, with test,
// add and delete commands and an APB-style configuration port.
// ============================================================================
// Usage:
//   A command transfer happens at a rising edge with start high and busy low.
//   It carries opcode and key words 0..4. The first hashes_per_key words,
//   masked to index_width bits, select counters in order.
//   Each command produces one result: out_valid is high for exactly one cycle
//   with member and op_done. The receiver cannot stall; results must be taken.
//   A command passes through the queue, the update engine and the result
//   register on its way to out_valid; the hash count is clamped to 0..5.
//   The update engine makes one counter read per cycle on the single store
//   read port, then finishes the last write-back and reports. A two-entry
//   queue lets the front end take further commands while the engine works.
//   Reset: the configuration returns to 5 hashes and 16 index bits, and a
//   clearing pass zeroes all 65536 counters; busy stays high for it.
//   Configuration is to be written only while no command is outstanding;
//   the block itself does not enforce this.
// ============================================================================
module counting_bloom_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [31:0]                        key_word0,
    input  logic [31:0]                        key_word1,
    input  logic [31:0]                        key_word2,
    input  logic [31:0]                        key_word3,
    input  logic [31:0]                        key_word4,
    // Result channel
    output logic                               out_valid,
    output logic                               member,
    output logic                               op_done,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [cbf_pkg::HASH_W-1:0]   hashes_reg, hashes_next;
    logic [cbf_pkg::IDXW_W-1:0]   idx_w_reg, idx_w_next;
    logic                         cfg_wr;
    logic                         push;
    logic                         pop;
    logic                         clearing;
    cbf_pkg::item_t               push_item;
    cbf_pkg::item_t               pop_item;
    cbf_pkg::q_status_t           q_status;
    cbf_pkg::result_t             result;
    logic                         out_valid_reg, out_valid_next;
    logic                         member_reg, member_next;
    logic                         op_done_reg, op_done_next;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        hashes_next = hashes_reg;
        idx_w_next  = idx_w_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                cbf_pkg::REG_HASHES: hashes_next = pwdata[cbf_pkg::HASH_W-1:0];
                cbf_pkg::REG_IDX_W:  idx_w_next  = pwdata[cbf_pkg::IDXW_W-1:0];
                default:             hashes_next = hashes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cbf_pkg::REG_HASHES: prdata = cbf_pkg::APB_DATA_W'(hashes_reg);
            cbf_pkg::REG_IDX_W:  prdata = cbf_pkg::APB_DATA_W'(idx_w_reg);
            default:             prdata = '0;
        endcase
    end

    // Front end.
    cbf_front u_front (
        .start          (start),
        .opcode         (opcode),
        .key_word0      (key_word0),
        .key_word1      (key_word1),
        .key_word2      (key_word2),
        .key_word3      (key_word3),
        .key_word4      (key_word4),
        .hashes_per_key (hashes_reg),
        .index_width    (idx_w_reg),
        .clearing       (clearing),
        .q_status       (q_status),
        .busy           (busy),
        .push           (push),
        .item           (push_item)
    );

    // Queue between front end and engine.
    cbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // Update engine with the counter store.
    cbf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (pop_item),
        .q_status (q_status),
        .pop      (pop),
        .clearing (clearing),
        .result   (result)
    );

    // Result register: one cycle strobe per completed command.
    always_comb
    begin
        out_valid_next = result.done;
        member_next    = result.done && result.member;
        op_done_next   = result.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hashes_reg    <= cbf_pkg::HASHES_RESET;
            idx_w_reg     <= cbf_pkg::IDX_W_RESET;
            out_valid_reg <= 1'b0;
            member_reg    <= 1'b0;
            op_done_reg   <= 1'b0;
        end
        else
        begin
            hashes_reg    <= hashes_next;
            idx_w_reg     <= idx_w_next;
            out_valid_reg <= out_valid_next;
            member_reg    <= member_next;
            op_done_reg   <= op_done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign member    = member_reg;
    assign op_done   = op_done_reg;

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the counting Bloom filter. A driver sends test, add
// and delete commands from a backlog, a monitor predicts each result from a
// shadow copy of the counter store, and filter settings change between
// phases over the APB port, with the extremes of hash count and index width.
// ============================================================================
module testbench;

    // One command: opcode and the five key words, word 0 in the low slot.
    typedef logic [cbf_pkg::MAX_HASHES-1:0][31:0] key_t;
    typedef struct packed {
        cbf_pkg::op_t op;
        key_t         words;
    } cmd_t;

    localparam logic [cbf_pkg::APB_ADDR_W-1:0] HASHES_ADDR = {cbf_pkg::REG_HASHES, 2'b00};
    localparam logic [cbf_pkg::APB_ADDR_W-1:0] IDX_W_ADDR  = {cbf_pkg::REG_IDX_W, 2'b00};
    localparam int STALL_LIMIT = 300000;
    localparam int POOL_SIZE   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = cbf_pkg::OP_TEST;
    logic [31:0] key_word0 = '0;
    logic [31:0] key_word1 = '0;
    logic [31:0] key_word2 = '0;
    logic [31:0] key_word3 = '0;
    logic [31:0] key_word4 = '0;
    logic        out_valid;
    logic        member;
    logic        op_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [cbf_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [cbf_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [cbf_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // Shadow of the filter: counters and the current settings.
    logic [cbf_pkg::CTR_W-1:0] ctr_shadow [cbf_pkg::STORE_DEPTH];
    int unsigned      filt_hashes;
    int unsigned      filt_idx_w;

    cmd_t        cmd_backlog [$];
    logic        member_due [$];
    key_t        key_pool [$];
    int unsigned sender_idle_pct = 37;
    logic        cmd_fire = 1'b0;
    int          stall_cycles = 0;
    int          fail_count = 0;

    counting_bloom_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .key_word0 (key_word0),
        .key_word1 (key_word1),
        .key_word2 (key_word2),
        .key_word3 (key_word3),
        .key_word4 (key_word4),
        .out_valid (out_valid),
        .member    (member),
        .op_done   (op_done),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock with a period of 4.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Applies one command to the shadow store and returns the expected member bit.
    function automatic logic bloom_apply(cbf_pkg::op_t op, key_t words);
        int unsigned                       k;
        int unsigned                       w;
        logic [31:0]                       mask;
        logic [cbf_pkg::INDEX_BITS-1:0]    slot;
        logic [cbf_pkg::CTR_W-1:0]         c;
        logic                              all_set;
        k = (filt_hashes > cbf_pkg::MAX_HASHES) ? cbf_pkg::MAX_HASHES : filt_hashes;
        w = (filt_idx_w > cbf_pkg::INDEX_BITS) ? cbf_pkg::INDEX_BITS : filt_idx_w;
        mask = (32'd1 << w) - 32'd1;
        all_set = 1'b1;
        for (int i = 0; i < k; i++)
        begin
            slot = words[i][cbf_pkg::INDEX_BITS-1:0] & mask[cbf_pkg::INDEX_BITS-1:0];
            c = ctr_shadow[slot];
            case (op)
                cbf_pkg::OP_TEST: if (c == cbf_pkg::CTR_ZERO) all_set = 1'b0;
                cbf_pkg::OP_ADD:  if (c != cbf_pkg::CTR_MAX) c = c + 1'b1;
                cbf_pkg::OP_DEL:
                    if (c != cbf_pkg::CTR_ZERO && c != cbf_pkg::CTR_MAX) c = c - 1'b1;
                default: ;
            endcase
            ctr_shadow[slot] = c;
        end
        return (op == cbf_pkg::OP_TEST) && all_set;
    endfunction

    // Random command; keys are often reused from recent adds so that tests
    // and deletes land on live counters.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        c.op = (pick < 35) ? cbf_pkg::OP_TEST :
               (pick < 75) ? cbf_pkg::OP_ADD  :
               (pick < 95) ? cbf_pkg::OP_DEL  : cbf_pkg::OP_NOP;
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 55)
        begin
            c.words = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 3) == 0)
                c.words[$urandom_range(0, cbf_pkg::MAX_HASHES - 1)] = $urandom;
        end
        else
        begin
            for (int i = 0; i < cbf_pkg::MAX_HASHES; i++)
            begin
                case ($urandom_range(0, 15))
                    0:       c.words[i] = '0;
                    1:       c.words[i] = '1;
                    default: c.words[i] = $urandom;
                endcase
            end
        end
        if (c.op == cbf_pkg::OP_ADD)
        begin
            key_pool.push_back(c.words);
            if (key_pool.size() > POOL_SIZE)
                void'(key_pool.pop_front());
        end
        return c;
    endfunction

    task automatic queue_cmd(input cbf_pkg::op_t op, input key_t words);
        cmd_t c;
        c.op = op;
        c.words = words;
        cmd_backlog.push_back(c);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [cbf_pkg::APB_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both registers (with junk in the unused bits) and reads them back.
    task automatic set_filter(input int unsigned hashes, input int unsigned idx_w);
        logic [31:0] rb;
        apb_access(1'b1, HASHES_ADDR, ($urandom & 32'hFFFF_FFF8) | hashes, rb);
        apb_access(1'b0, HASHES_ADDR, '0, rb);
        if (rb[cbf_pkg::HASH_W-1:0] !== cbf_pkg::HASH_W'(hashes))
        begin
            $error("hashes_per_key: expected %0d, got %0d", hashes,
                   rb[cbf_pkg::HASH_W-1:0]);
            fail_count++;
        end
        apb_access(1'b1, IDX_W_ADDR, ($urandom & 32'hFFFF_FFE0) | idx_w, rb);
        apb_access(1'b0, IDX_W_ADDR, '0, rb);
        if (rb[cbf_pkg::IDXW_W-1:0] !== cbf_pkg::IDXW_W'(idx_w))
        begin
            $error("index_width: expected %0d, got %0d", idx_w,
                   rb[cbf_pkg::IDXW_W-1:0]);
            fail_count++;
        end
        filt_hashes = hashes;
        filt_idx_w  = idx_w;
    endtask

    // Waits until every command has been sent and answered.
    task automatic drain();
        while (cmd_backlog.size() != 0 || start || member_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned hashes, input int unsigned idx_w,
                             input int count, input int unsigned idle_pct);
        drain();
        set_filter(hashes, idx_w);
        sender_idle_pct = idle_pct;
        repeat (count) cmd_backlog.push_back(random_cmd());
    endtask

    // Command driver: presents the next command once the current one is taken.
    always @(negedge clk)
    begin : cmd_driver
        cmd_t nxt;
        if (rst_n && (!start || cmd_fire))
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                nxt = cmd_backlog.pop_front();
                start     <= 1'b1;
                opcode    <= nxt.op;
                key_word0 <= nxt.words[0];
                key_word1 <= nxt.words[1];
                key_word2 <= nxt.words[2];
                key_word3 <= nxt.words[3];
                key_word4 <= nxt.words[4];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: predicts on each command transfer, checks each result.
    always @(posedge clk)
    begin : result_monitor
        logic exp_member;
        cmd_fire = rst_n && start && !busy;
        if (cmd_fire)
            member_due.push_back(bloom_apply(cbf_pkg::op_t'(opcode),
                {key_word4, key_word3, key_word2, key_word1, key_word0}));
        if (rst_n && out_valid)
        begin
            if (member_due.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end
            else
            begin
                exp_member = member_due.pop_front();
                if (member !== exp_member)
                begin
                    $error("member: expected %0b, got %0b", exp_member, member);
                    fail_count++;
                end
                if (op_done !== 1'b1)
                begin
                    $error("op_done: expected 1, got %0b", op_done);
                    fail_count++;
                end
            end
        end
        if (cmd_fire || (rst_n && out_valid))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence.
    initial
    begin
        for (int i = 0; i < cbf_pkg::STORE_DEPTH; i++)
            ctr_shadow[i] = cbf_pkg::CTR_ZERO;
        filt_hashes = cbf_pkg::HASHES_RESET;
        filt_idx_w  = cbf_pkg::IDX_W_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands at the reset settings (5 hashes, 16 index bits).
        queue_cmd(cbf_pkg::OP_TEST, '0);        // empty store: not a member
        queue_cmd(cbf_pkg::OP_ADD, '0);         // same slot five times
        queue_cmd(cbf_pkg::OP_TEST, '0);
        queue_cmd(cbf_pkg::OP_ADD, '1);
        queue_cmd(cbf_pkg::OP_ADD, '1);
        queue_cmd(cbf_pkg::OP_ADD, '1);         // reaches the ceiling
        queue_cmd(cbf_pkg::OP_ADD, '1);         // saturates
        queue_cmd(cbf_pkg::OP_DEL, '1);         // a full counter stays full
        queue_cmd(cbf_pkg::OP_TEST, '1);
        queue_cmd(cbf_pkg::OP_DEL, '0);         // back to zero
        queue_cmd(cbf_pkg::OP_DEL, '0);         // no underflow
        queue_cmd(cbf_pkg::OP_TEST, '0);
        queue_cmd(cbf_pkg::OP_NOP, '1);         // NOP opcode leaves the store unchanged
        queue_cmd(cbf_pkg::OP_TEST, '1);
        queue_cmd(cbf_pkg::OP_ADD, {32'h0000_0100, 32'h5555_0100, 32'h0F0F_0100,
                                    32'hABCD_0007, 32'h1234_0007});
        queue_cmd(cbf_pkg::OP_TEST, {32'h0000_0100, 32'h5555_0100, 32'h0F0F_0100,
                                     32'hABCD_0007, 32'hFFFF_0007});
        queue_cmd(cbf_pkg::OP_TEST, {32'h0000_0100, 32'h5555_0100, 32'h0F0F_0100,
                                     32'hABCD_0007, 32'h1234_0008});
        queue_cmd(cbf_pkg::OP_DEL, {32'h0000_FFFF, 32'hAAAA_FFFF, 32'h1111_FFFF,
                                    32'h8000_FFFF, 32'h7FFF_FFFF});

        // Random phases: sender idles 37%, then 71%, then not at all.
        run_phase(5, 16, 60, 37);
        run_phase(1, 3, 60, 37);
        run_phase(0, 8, 30, 37);                // no counters selected
        run_phase(7, 0, 30, 71);                // clamped hashes, everything in slot 0
        run_phase(3, 31, 60, 71);               // index width above the store
        run_phase(6, 5, 60, 71);
        run_phase(2, 17, 60, 0);
        run_phase(5, 4, 80, 0);
        run_phase(4, 10, 60, 0);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
